### rtl/tgr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgr_pkg: shared definitions for the text glyph renderer
// Font store geometry, cursor offsets, item and register codes, sequencer
// states and the font store request bundle.
// ----------------------------------------------------------------------------
package tgr_pkg;

	// Font and framebuffer geometry
	localparam int GLYPH_COUNT = 256;
	localparam int ROW_STRIDE  = 1024;
	localparam int TAB_CELLS   = 8;

	localparam int CELL_PX     = 8;
	localparam int X_OFFSET    = 16;
	localparam int Y_OFFSET    = 12;
	localparam int SPACE_CODE  = 32;
	localparam int STORE_BYTES = GLYPH_COUNT * 8;
	localparam int STORE_AW    = $clog2(STORE_BYTES);
	localparam int CODE_AW     = STORE_AW - 3;

	// Field widths
	localparam int ADDR_W  = 20;
	localparam int CUR_W   = 16;
	localparam int COLOR_W = 16;
	localparam int CFG_W   = 16;
	localparam int COL_W   = CUR_W - 3;
	localparam int CELLS_W = 4;

	// Reciprocal used to reduce the cursor column modulo the tab stop
	localparam int TAB_RECIP_SH = 16;
	localparam int TAB_RECIP    = (1 << TAB_RECIP_SH) / TAB_CELLS;
	localparam int TAB_RECIP_W  = TAB_RECIP_SH + 1;
	localparam int TAB_PROD_W   = COL_W + TAB_RECIP_W;

	// Register reset values
	localparam logic [COLOR_W-1:0] FORE_RESET = 16'hFFFF;
	localparam logic [COLOR_W-1:0] BACK_RESET = 16'h0000;

	// Item kinds
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_BEGIN = 2'd1;
	localparam logic [1:0] KIND_CHAR  = 2'd2;

	// Control characters
	localparam logic [7:0] CHAR_TAB = 8'd9;
	localparam logic [7:0] CHAR_NL  = 8'd10;
	localparam logic [7:0] CHAR_CR  = 8'd13;

	// Configuration register indexes
	localparam logic [1:0] CFG_START_COL  = 2'd0;
	localparam logic [1:0] CFG_START_ROW  = 2'd1;
	localparam logic [1:0] CFG_FORE_COLOR = 2'd2;
	localparam logic [1:0] CFG_BACK_COLOR = 2'd3;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAB_MUL,
		ST_TAB_CNT,
		ST_CELL,
		ST_ROWS
	} state_t;

	// Font store access bundle
	typedef struct packed {
		logic                wr_en;
		logic [STORE_AW-1:0] wr_addr;
		logic [7:0]          wr_data;
		logic                rd_en;
		logic [STORE_AW-1:0] rd_addr;
	} font_req_t;

endpackage
`default_nettype wire

### rtl/tgr_font_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgr_font_store: glyph row memory
// One write port and one read port; read data is registered and holds
// while no read is requested.
// ----------------------------------------------------------------------------
module tgr_font_store (
	input  logic               clk,
	input  tgr_pkg::font_req_t req,
	output logic [7:0]         rd_data
);
	import tgr_pkg::*;

	logic [7:0] mem [STORE_BYTES];

	// Write a loaded font byte
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// Register the row read
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule
`default_nettype wire

### rtl/text_glyph_renderer_unit.sv
`default_nettype none
// Printable code: accepted while the sequencer is idle, then a cell setup state and one row per cycle
//   while the output is not stalled; input is stalled until the character is drawn.
// Tab: the tab stop reduction in ST_TAB_MUL and ST_TAB_CNT, then one blank cell per cell to the stop (up to 8 cells).
// Font load, begin, newline, return: accepted while idle, no result items.
// Reset clears cursor, registers and sequencer; the font store is not cleared and must be
//   loaded before use, so there is no clearing pass.
// ----------------------------------------------------------------------------
// text_glyph_renderer_unit: 8x8 character generator
// Turns font load, begin and character items into framebuffer row writes
// using a font store and one shared address adder under a small sequencer.
// ----------------------------------------------------------------------------
module text_glyph_renderer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_index,
	input  logic [tgr_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  kind,
	input  logic [10:0]                 font_index,
	input  logic [7:0]                  font_byte,
	input  logic [7:0]                  char_code,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tgr_pkg::ADDR_W-1:0]  pixel_addr,
	output logic [7:0]                  glyph_bits,
	output logic [tgr_pkg::COLOR_W-1:0] ink_color,
	output logic [tgr_pkg::COLOR_W-1:0] paper_color,
	output logic                        paper_enable,
	output logic                        last
);
	import tgr_pkg::*;

	// Configuration registers
	logic [6:0]         start_col_q;
	logic [6:0]         start_row_q;
	logic [COLOR_W-1:0] fore_q;
	logic [COLOR_W-1:0] back_q;

	// Cursor and sequencer
	logic [CUR_W-1:0]      cursor_x_q;
	logic [CUR_W-1:0]      cursor_y_q;
	state_t                state_q;
	state_t                state_d;
	logic [7:0]            code_q;
	logic [COLOR_W-1:0]    cell_ink_q;
	logic [CELLS_W-1:0]    cells_q;
	logic [2:0]            row_q;
	logic [ADDR_W-1:0]     base_q;
	logic [TAB_PROD_W-1:0] prod_q;

	// Output register
	logic               out_valid_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [COLOR_W-1:0] ink_q;
	logic [COLOR_W-1:0] paper_q;
	logic               paper_en_q;
	logic               last_q;
	logic               blank_q;

	// Combinational
	logic                accept_in;
	logic                out_free;
	logic                row_load;
	logic                cell_end;
	logic [CUR_W-1:0]    start_x;
	logic [CUR_W-1:0]    start_y;
	logic [ADDR_W-1:0]   add_a;
	logic [ADDR_W-1:0]   add_b;
	logic [ADDR_W-1:0]   add_sum;
	logic [COL_W-1:0]    col;
	logic [COL_W:0]      quot;
	logic [CUR_W-1:0]    quot_t;
	logic [CUR_W-1:0]    rem_raw;
	logic [CUR_W-1:0]    rem_fix;
	logic [CELLS_W-1:0]  tab_cells;
	logic                code_in_range;
	font_req_t           font_req;
	logic [7:0]          rd_data;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign row_load  = (state_q == ST_ROWS) && out_free;
	assign cell_end  = row_load && (row_q == 3'd7);

	assign start_x = CUR_W'({start_col_q, 3'b000}) + CUR_W'(X_OFFSET);
	assign start_y = CUR_W'({start_row_q, 3'b000}) + CUR_W'(Y_OFFSET);

	// Shared address adder: cell base on setup, next row address while drawing
	always_comb begin
		if (state_q == ST_CELL) begin
			add_a = ADDR_W'(cursor_x_q);
			add_b = {{(ADDR_W-CUR_W){1'b0}}, cursor_y_q} * ADDR_W'(ROW_STRIDE);
		end else begin
			add_a = base_q;
			add_b = ADDR_W'(ROW_STRIDE);
		end
		add_sum = add_a + add_b;
	end

	// Reduce the cell column modulo the tab stop and count cells to the stop
	always_comb begin
		col     = cursor_x_q[CUR_W-1:3];
		quot    = prod_q[TAB_PROD_W-1:TAB_RECIP_SH];
		quot_t  = CUR_W'(quot * TAB_CELLS);
		rem_raw = CUR_W'(col) - quot_t;
		rem_fix = (rem_raw >= CUR_W'(TAB_CELLS)) ? (rem_raw - CUR_W'(TAB_CELLS)) : rem_raw;
		tab_cells = CELLS_W'(TAB_CELLS) - CELLS_W'(rem_fix)
			- {{(CELLS_W-1){1'b0}}, |cursor_x_q[2:0]};
	end

	assign code_in_range = ({1'b0, code_q} < 9'(GLYPH_COUNT));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_in && kind == KIND_CHAR) begin
					case (char_code)
						CHAR_TAB: state_d = ST_TAB_MUL;
						CHAR_NL:  state_d = ST_IDLE;
						CHAR_CR:  state_d = ST_IDLE;
						default:  state_d = ST_CELL;
					endcase
				end
			end
			ST_TAB_MUL: state_d = ST_TAB_CNT;
			ST_TAB_CNT: state_d = (tab_cells == '0) ? ST_IDLE : ST_CELL;
			ST_CELL:    state_d = ST_ROWS;
			ST_ROWS: begin
				if (cell_end) begin
					state_d = (cells_q == CELLS_W'(1)) ? ST_IDLE : ST_CELL;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_col_q <= '0;
			start_row_q <= '0;
			fore_q      <= FORE_RESET;
			back_q      <= BACK_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_START_COL:  start_col_q <= cfg_data[6:0];
				CFG_START_ROW:  start_row_q <= cfg_data[6:0];
				CFG_FORE_COLOR: fore_q      <= cfg_data[COLOR_W-1:0];
				CFG_BACK_COLOR: back_q      <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// Move the cursor on begin, newline, return and at the end of each cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else if (accept_in) begin
			if (kind == KIND_BEGIN) begin
				cursor_x_q <= start_x;
				cursor_y_q <= start_y;
			end else if (kind == KIND_CHAR && char_code == CHAR_NL) begin
				cursor_x_q <= start_x;
				cursor_y_q <= cursor_y_q + CUR_W'(CELL_PX);
			end else if (kind == KIND_CHAR && char_code == CHAR_CR) begin
				cursor_x_q <= start_x;
			end
		end else if (cell_end) begin
			cursor_x_q <= cursor_x_q + CUR_W'(CELL_PX);
		end
	end

	// Track cells left in the item and the row within the cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q <= '0;
			row_q   <= '0;
		end else begin
			if (accept_in) begin
				cells_q <= CELLS_W'(1);
			end else if (state_q == ST_TAB_CNT) begin
				cells_q <= tab_cells;
			end else if (cell_end) begin
				cells_q <= cells_q - CELLS_W'(1);
			end
			if (row_load) begin
				row_q <= row_q + 3'd1;
			end
		end
	end

	// Latch the glyph code, ink color, cell base and tab product
	always_ff @(posedge clk) begin
		if (accept_in) begin
			if (char_code == CHAR_TAB) begin
				code_q     <= 8'(SPACE_CODE);
				cell_ink_q <= back_q;
			end else begin
				code_q     <= char_code;
				cell_ink_q <= fore_q;
			end
		end
		if (state_q == ST_TAB_MUL) begin
			prod_q <= TAB_PROD_W'(col) * TAB_PROD_W'(TAB_RECIP);
		end
		if (state_q == ST_CELL || row_load) begin
			base_q <= add_sum;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (row_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load one row item into the output register
	always_ff @(posedge clk) begin
		if (row_load) begin
			addr_q     <= base_q;
			ink_q      <= cell_ink_q;
			paper_q    <= back_q;
			paper_en_q <= (fore_q != back_q);
			last_q     <= (row_q == 3'd7) && (cells_q == CELLS_W'(1));
			blank_q    <= !code_in_range;
		end
	end

	// Font store access
	always_comb begin
		font_req.wr_en   = accept_in && (kind == KIND_LOAD)
			&& ({1'b0, font_index} < 12'(STORE_BYTES));
		font_req.wr_addr = font_index[STORE_AW-1:0];
		font_req.wr_data = font_byte;
		font_req.rd_en   = row_load;
		font_req.rd_addr = {code_q[CODE_AW-1:0], row_q};
	end

	tgr_font_store u_font_store (
		.clk     (clk),
		.req     (font_req),
		.rd_data (rd_data)
	);

	assign out_valid    = out_valid_q;
	assign pixel_addr   = addr_q;
	assign glyph_bits   = blank_q ? 8'h00 : rd_data;
	assign ink_color    = ink_q;
	assign paper_color  = paper_q;
	assign paper_enable = paper_en_q;
	assign last         = last_q;

	// Drawing always has a cell left to draw
	a_rows_have_cells: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROWS) |-> (cells_q != '0))
		else $error("drawing rows with no cell left");

	// Row counter sits at the top row outside of drawing
	a_row_at_top: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ROWS) |-> (row_q == 3'd0))
		else $error("row counter not at top row between cells");

	// A waiting row item that is not the final one means the item is still drawing
	a_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> (state_q == ST_ROWS || state_q == ST_CELL))
		else $error("non-final row item with sequencer not drawing");

endmodule
`default_nettype wire
